FILE: design/mac_pkg.sv
`default_nettype none
package mac_pkg;

	// Longest address in bytes; the byte at this count ends the address.
	localparam int MAX_LEN = 256;

	localparam int POS_W   = $clog2(MAX_LEN);
	localparam int LEN_W   = 9;
	localparam int EXT_W   = (POS_W > LEN_W) ? POS_W : LEN_W;
	localparam int IN_W    = 8;
	localparam int OUT_W   = 16;

	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(MAX_LEN - 1);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN % 512);

	localparam logic [IN_W-1:0] CH_NUL = 8'h00;
	localparam logic [IN_W-1:0] CH_AT  = 8'h40;
	localparam logic [IN_W-1:0] CH_DOT = 8'h2E;

	typedef enum logic [1:0] {
		VERDICT_OK         = 2'd0,
		VERDICT_STRING_END = 2'd1,
		VERDICT_FORMAT     = 2'd2
	} verdict_t;

	typedef struct packed {
		logic is_nul;
		logic is_at;
		logic is_dot;
		logic local_ok;
		logic host_ok;
	} byte_class_t;

	typedef struct packed {
		logic             valid;
		verdict_t         verdict;
		logic [LEN_W-1:0] len;
	} result_t;

	function automatic logic [LEN_W-1:0] pos_to_len(input logic [POS_W-1:0] p);
		logic [EXT_W-1:0] e;
		e = EXT_W'(p);
		return e[LEN_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: design/mac_classify.sv
`default_nettype none
module mac_classify (
	input  wire logic [mac_pkg::IN_W-1:0] char_byte,
	output mac_pkg::byte_class_t          cls
);
	import mac_pkg::*;

	logic special;
	logic printable;

	always_comb begin
		case (char_byte) inside
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h5B, 8'h5D,
			8'h3A, 8'h3B, 8'h5C, 8'h2C, 8'h22: special = 1'b1;
			default: special = 1'b0;
		endcase
	end

	assign printable = (char_byte >= 8'h21) && (char_byte <= 8'h7E);

	always_comb begin
		cls.is_nul   = (char_byte == CH_NUL);
		cls.is_at    = (char_byte == CH_AT);
		cls.is_dot   = (char_byte == CH_DOT);
		cls.local_ok = printable && !special;
		cls.host_ok  = ((char_byte >= 8'h30) && (char_byte <= 8'h39))
			|| ((char_byte >= 8'h61) && (char_byte <= 8'h7A))
			|| ((char_byte >= 8'h41) && (char_byte <= 8'h5A))
			|| (char_byte == 8'h2D) || (char_byte == 8'h5F);
	end

endmodule
`default_nettype wire

FILE: design/mac_track.sv
`default_nettype none
module mac_track (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire mac_pkg::byte_class_t cls,
	output mac_pkg::result_t     res
);
	import mac_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             in_host_q;
	logic             host_any_q;
	logic             prev_dot_q;
	logic             bad_q;
	logic             discard_q;

	logic [POS_W-1:0] pos_d;
	logic             in_host_d;
	logic             host_any_d;
	logic             prev_dot_d;
	logic             bad_d;
	logic             discard_d;

	always_comb begin
		pos_d       = pos_q;
		in_host_d   = in_host_q;
		host_any_d  = host_any_q;
		prev_dot_d  = prev_dot_q;
		bad_d       = bad_q;
		discard_d   = discard_q;
		res.valid   = 1'b0;
		res.verdict = VERDICT_OK;
		res.len     = pos_to_len(pos_q);

		if (discard_q) begin
			// drop bytes up to the terminator; address state is already clear
			if (cls.is_nul) begin
				discard_d = 1'b0;
			end
		end else if (cls.is_nul) begin
			res.valid = 1'b1;
			if (pos_q == '0 || !in_host_q || !host_any_q || prev_dot_q || bad_q) begin
				res.verdict = VERDICT_FORMAT;
			end
			pos_d      = '0;
			in_host_d  = 1'b0;
			host_any_d = 1'b0;
			prev_dot_d = 1'b0;
			bad_d      = 1'b0;
		end else begin
			if (!in_host_q) begin
				if (cls.is_at) begin
					if (pos_q == '0) begin
						bad_d = 1'b1;
					end
					in_host_d = 1'b1;
				end else if (!cls.local_ok) begin
					bad_d = 1'b1;
				end
			end else begin
				if (cls.is_dot) begin
					if (!host_any_q || prev_dot_q) begin
						bad_d = 1'b1;
					end
					prev_dot_d = 1'b1;
				end else begin
					if (!cls.host_ok) begin
						bad_d = 1'b1;
					end
					prev_dot_d = 1'b0;
				end
				host_any_d = 1'b1;
			end

			if (pos_q == POS_LAST) begin
				res.valid   = 1'b1;
				res.verdict = VERDICT_STRING_END;
				res.len     = LEN_LIMIT;
				pos_d       = '0;
				in_host_d   = 1'b0;
				host_any_d  = 1'b0;
				prev_dot_d  = 1'b0;
				bad_d       = 1'b0;
				discard_d   = 1'b1;
			end else begin
				pos_d = pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			in_host_q  <= 1'b0;
			host_any_q <= 1'b0;
			prev_dot_q <= 1'b0;
			bad_q      <= 1'b0;
			discard_q  <= 1'b0;
		end else if (step) begin
			pos_q      <= pos_d;
			in_host_q  <= in_host_d;
			host_any_q <= host_any_d;
			prev_dot_q <= prev_dot_d;
			bad_q      <= bad_d;
			discard_q  <= discard_d;
		end
	end

	a_discard_clear: assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> (pos_q == '0) && !in_host_q && !host_any_q && !bad_q)
		else $error("address state not clear while dropping bytes");

	a_limit_discard: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && (res.verdict == VERDICT_STRING_END) |=> discard_q)
		else $error("limit hit without entering drop mode");

	a_result_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid |=> (pos_q == '0) && !in_host_q)
		else $error("address state not restarted after a verdict");

	a_dot_in_host: assert property (@(posedge clk) disable iff (!arst_n)
		prev_dot_q |-> in_host_q && host_any_q)
		else $error("dot flag set outside the host part");

endmodule
`default_nettype wire

FILE: design/mail_address_checker.sv
`default_nettype none
// E-mail address format checker. Feed the address one byte per beat on the
// s_ stream, ending with a NUL byte; one verdict beat comes out on the m_
// stream per address: ok, string_end (no NUL within MAX_LEN bytes) or
// format_error, together with the address length. An empty address is a
// format error. When the limit is hit the verdict comes at the MAX_LEN-th
// byte and all bytes up to and including the next NUL are dropped silently.
// The block takes one byte per clock cycle unless a waiting verdict holds it
// back: a byte is registered in the input register, then classified and
// checked against the running address state, and its verdict (if any) is
// registered in the output register.
// A waiting verdict blocks only the next byte that itself ends an address.
module mail_address_checker (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [mac_pkg::IN_W-1:0]  s_tdata,  // [7:0] char_byte
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [mac_pkg::OUT_W-1:0]     m_tdata   // [1:0] verdict, [10:2] addr_length
);
	import mac_pkg::*;

	// input register
	logic [IN_W-1:0] byte_s1;
	logic            valid_s1;

	// result register
	logic             valid_s2;
	verdict_t         verdict_s2;
	logic [LEN_W-1:0] len_s2;

	byte_class_t cls;
	result_t     res;
	logic        out_free;
	logic        consume;

	mac_classify u_classify (
		.char_byte (byte_s1),
		.cls       (cls)
	);

	mac_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume),
		.cls    (cls),
		.res    (res)
	);

	// a byte without a verdict can always advance; one with a verdict
	// waits for the output register to drain
	assign out_free = !valid_s2 || m_tready;
	assign consume  = valid_s1 && (!res.valid || out_free);
	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// hold the byte until it is consumed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (consume && res.valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && res.valid) begin
			verdict_s2 <= res.verdict;
			len_s2     <= res.len;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(OUT_W - LEN_W - 2)'(0), len_s2, verdict_s2};

endmodule
`default_nettype wire

FILE: dv/mac_verdict_checker.sv
module mac_verdict_checker (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	input  wire logic                      s_tready,
	input  wire logic [mac_pkg::IN_W-1:0]  s_tdata,  // [7:0] char_byte
	input  wire logic                      m_tvalid,
	input  wire logic                      m_tready,
	input  wire logic [mac_pkg::OUT_W-1:0] m_tdata,  // [1:0] verdict, [10:2] addr_length
	output int                             errors,
	output int                             pending
);
	import mac_pkg::*;

	localparam int VERDICT_LSB = 0;
	localparam int LENGTH_LSB  = 2;
	localparam int PAD_LSB     = LENGTH_LSB + LEN_W;
	localparam int HOST_SAT    = 511;

	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_RPAREN = ")";
	localparam logic [7:0] CH_LT     = "<";
	localparam logic [7:0] CH_GT     = ">";
	localparam logic [7:0] CH_LBRACK = "[";
	localparam logic [7:0] CH_RBRACK = "]";
	localparam logic [7:0] CH_COLON  = ":";
	localparam logic [7:0] CH_SEMI   = ";";
	localparam logic [7:0] CH_BSLASH = "\\";
	localparam logic [7:0] CH_COMMA  = ",";
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_DASH   = "-";
	localparam logic [7:0] CH_UNDER  = "_";
	localparam logic [7:0] CH_PRINT_LO = 8'h21;
	localparam logic [7:0] CH_PRINT_HI = "~";

	typedef struct packed {
		verdict_t         verdict;
		logic [LEN_W-1:0] len;
	} verdict_beat_t;

	verdict_beat_t expected_verdicts[$];

	// running view of the address being received
	int unsigned addr_pos;
	int unsigned host_len;
	bit          seen_at;
	bit          last_dot;
	bit          addr_bad;
	bit          dropping;

	function automatic bit is_local_special(input logic [7:0] b);
		case (b)
			CH_LPAREN, CH_RPAREN, CH_LT, CH_GT, CH_LBRACK, CH_RBRACK,
			CH_COLON, CH_SEMI, CH_BSLASH, CH_COMMA, CH_DQUOTE: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit is_host_legal(input logic [7:0] b);
		return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
			(b >= "A" && b <= "Z") || b == CH_DASH || b == CH_UNDER;
	endfunction

	task automatic restart_address();
		addr_pos = 0;
		host_len = 0;
		seen_at  = 1'b0;
		last_dot = 1'b0;
		addr_bad = 1'b0;
	endtask

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	// Advance the address state by one byte; queue a verdict when one is due.
	task automatic predict_verdict(input logic [7:0] b);
		verdict_beat_t v;
		if (dropping) begin
			if (b == CH_NUL) begin
				dropping = 1'b0;
				restart_address();
			end
			return;
		end
		if (b == CH_NUL) begin
			if (addr_pos == 0 || !seen_at || host_len == 0 || last_dot || addr_bad)
				v.verdict = VERDICT_FORMAT;
			else
				v.verdict = VERDICT_OK;
			v.len = LEN_W'(addr_pos);
			expected_verdicts.push_back(v);
			restart_address();
			return;
		end
		if (!seen_at) begin
			if (b == CH_AT) begin
				if (addr_pos == 0)
					addr_bad = 1'b1;
				seen_at = 1'b1;
			end else if (b < CH_PRINT_LO || b > CH_PRINT_HI || is_local_special(b)) begin
				addr_bad = 1'b1;
			end
		end else begin
			if (b == CH_DOT) begin
				if (host_len == 0 || last_dot)
					addr_bad = 1'b1;
				last_dot = 1'b1;
			end else begin
				if (!is_host_legal(b))
					addr_bad = 1'b1;
				last_dot = 1'b0;
			end
			if (host_len < HOST_SAT)
				host_len++;
		end
		addr_pos++;
		if (addr_pos >= MAX_LEN) begin
			v.verdict = VERDICT_STRING_END;
			v.len     = LEN_W'(MAX_LEN);
			expected_verdicts.push_back(v);
			restart_address();
			dropping = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_beat_t want;
		if (!arst_n) begin
			expected_verdicts.delete();
			restart_address();
			dropping = 1'b0;
			errors   = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch($sformatf("verdict beat 0x%h with none expected", m_tdata));
				end else begin
					want = expected_verdicts.pop_front();
					if (m_tdata[VERDICT_LSB +: 2] !== want.verdict)
						report_mismatch($sformatf("verdict %0d, expected %0d",
							m_tdata[VERDICT_LSB +: 2], want.verdict));
					if (m_tdata[LENGTH_LSB +: LEN_W] !== want.len)
						report_mismatch($sformatf("addr_length %0d, expected %0d",
							m_tdata[LENGTH_LSB +: LEN_W], want.len));
					if (m_tdata[OUT_W-1:PAD_LSB] !== '0)
						report_mismatch($sformatf("pad bits 0x%h, expected zero",
							m_tdata[OUT_W-1:PAD_LSB]));
				end
			end
			if (s_tvalid && s_tready)
				predict_verdict(s_tdata);
			pending <= expected_verdicts.size();
		end
	end

endmodule

FILE: dv/tb_mail_address_checker.sv
module tb_mail_address_checker;
	import mac_pkg::*;

	// Random part stops once this many short-address bytes have gone in.
	localparam int ITEM_TARGET    = 170;
	// Receiver hold-off long enough to back the block up into its input.
	localparam int LONG_HOLD      = 300;
	// No beat in this many cycles means the block is hung.
	localparam int WATCHDOG_LIMIT = 3000;
	// Extra cycles after the drain to catch stray beats.
	localparam int DRAIN_CYCLES   = 10;
	localparam int HOLD_AT        = 40;
	localparam int PAUSE_AT       = 110;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;   // [7:0] char_byte
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;        // [1:0] verdict, [10:2] addr_length

	int chk_errors;
	int chk_pending;

	// Byte pools for address content.
	string LOCAL_SET = "abcdxyzABCQZ0189!#$%&'*+-/=?^_`{|}~.";
	string HOST_SET  = "abcdefxyzABCXYZ0123789-_";
	string ODD_SET   = " ()<>[]:;\\,\"@..~!\x7f\x80\xff";

	logic [7:0] addr_q[$];
	int         burst_left = 0;
	bit         steady     = 1'b0;
	int         hold_token = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mail_address_checker dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	mac_verdict_checker verdict_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (chk_errors),
		.pending  (chk_pending)
	);

	// Receiver: stall on a random 16-bit ready mask, often all ready.
	// A new hold_token value starts a long hold-off counted here.
	int          hold_left = 0;
	int          hold_seen = 0;
	int          mask_step = 0;
	logic [15:0] ready_mask;

	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (mask_step == 0) begin
				ready_mask = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom | $urandom);
				mask_step  = 16;
			end
			mask_step--;
			m_tready <= ready_mask[mask_step];
		end
	end

	// Watchdog: count cycles with no beat on either side.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [7:0] pick_from(input string pool);
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	// Half from the troublemaker set, half any non-NUL byte.
	function automatic logic [7:0] pick_odd_byte();
		if ($urandom_range(0, 1) == 0)
			return pick_from(ODD_SET);
		return 8'($urandom_range(1, 255));
	endfunction

	// Offer one byte and hold it until it is taken. Bursts of random length
	// alternate with short gaps unless a steady stretch is running.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = $urandom_range(0, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_address();
		foreach (addr_q[i])
			send_byte(addr_q[i]);
	endtask

	// Drop the valid and wait for every outstanding verdict.
	task automatic drain_verdicts();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (chk_pending != 0);
	endtask

	// Well-formed address with random content, sometimes with one defect.
	task automatic build_wellformed();
		int labels;
		int idx;
		addr_q.delete();
		repeat ($urandom_range(1, 6))
			addr_q.push_back(pick_from(LOCAL_SET));
		addr_q.push_back(CH_AT);
		labels = $urandom_range(1, 3);
		for (int l = 0; l < labels; l++) begin
			if (l > 0)
				addr_q.push_back(CH_DOT);
			repeat ($urandom_range(1, 5))
				addr_q.push_back(pick_from(HOST_SET));
		end
		if ($urandom_range(0, 9) < 3) begin
			idx = $urandom_range(0, addr_q.size() - 1);
			case ($urandom_range(0, 3))
				0: addr_q[idx] = pick_odd_byte();
				1: addr_q[idx] = CH_DOT;
				2: addr_q[idx] = CH_AT;
				default: addr_q.push_back(CH_DOT);
			endcase
		end
		addr_q.push_back(CH_NUL);
	endtask

	// Long address: '@' in the middle, host characters around it, then junk
	// that the block should drop once the limit has been hit.
	task automatic send_long(input int body_len, input int junk_len);
		addr_q.delete();
		for (int i = 0; i < body_len; i++)
			addr_q.push_back((i == body_len / 2) ? CH_AT : pick_from(HOST_SET));
		repeat (junk_len)
			addr_q.push_back(8'($urandom_range(1, 255)));
		addr_q.push_back(CH_NUL);
		send_address();
	endtask

	initial begin
		int  random_sent;
		int  kind;
		bit  held;
		bit  paused;

		random_sent = 0;
		held        = 1'b0;
		paused      = 1'b0;

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty address, printable extremes around a valid address with
		// a dotted host that passes, leading '@', a second '@' in the host, a high
		// byte, and a host dot that is both leading and trailing.
		addr_q = '{CH_NUL,
			8'h21, "~", CH_AT, "a", CH_DOT, "b", CH_NUL,
			CH_AT, "a", CH_NUL,
			"a", CH_AT, CH_AT, CH_NUL,
			8'hFF, CH_AT, "a", CH_NUL,
			"a", CH_AT, CH_DOT, CH_NUL};
		send_address();

		// Length limit: exactly at it, with junk to drop up to the terminator.
		send_long(MAX_LEN, 4);

		while (random_sent < ITEM_TARGET) begin
			// Start the long receiver hold-off and keep offering bytes.
			if (!held && random_sent >= HOLD_AT) begin
				hold_token <= hold_token + 1;
				held = 1'b1;
			end
			if (!paused && random_sent >= PAUSE_AT) begin
				drain_verdicts();
				paused = 1'b1;
			end
			// Every fourth stretch of about 60 bytes runs without gaps.
			steady = ((random_sent / 60) % 4) == 1;

			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				build_wellformed();
			end else if (kind < 80) begin
				addr_q.delete();
				repeat ($urandom_range(0, 8))
					addr_q.push_back(pick_odd_byte());
				addr_q.push_back(CH_NUL);
			end else begin
				// Local part only, optionally with an empty host.
				addr_q.delete();
				repeat ($urandom_range(1, 4))
					addr_q.push_back(pick_from(LOCAL_SET));
				if ($urandom_range(0, 1) == 0)
					addr_q.push_back(CH_AT);
				addr_q.push_back(CH_NUL);
			end
			random_sent += addr_q.size();
			send_address();
		end

		drain_verdicts();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (chk_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
design/mac_pkg.sv
design/mac_classify.sv
design/mac_track.sv
design/mail_address_checker.sv
dv/mac_verdict_checker.sv
dv/tb_mail_address_checker.sv
